FILE: sv/cfb_pkg.sv
// ---------------------------------------------------------------------------
// cfb_pkg
// Shared types, codes and constants of the chained free block list allocator.
// ---------------------------------------------------------------------------
package cfb_pkg;

    // divider operand width: covers head positions up to 65536 and NUM_BLOCKS
    localparam int DIV_W   = 17;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 16;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_BYTES_PER_BLOCK    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_INODE_COUNT        = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_BYTES_PER_INODE    = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_INITIAL_FREE_COUNT = 2'd3;

    // register reset values
    localparam logic [12:0] BPB_RST  = 13'd512;
    localparam logic [15:0] IC_RST   = 16'd64;
    localparam logic [10:0] BPI_RST  = 11'd128;
    localparam logic [15:0] FREE_RST = 16'd0;

    // operation and status codes
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_FREE    = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] freed_block;
    } cfb_in_t;

    typedef struct packed {
        logic [7:0]  granted_block;
        logic        status;
        logic [15:0] free_count;
    } cfb_out_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE,
        ST_PER_GO, ST_PER_WAIT, ST_HEAD_GO, ST_HEAD_WAIT,
        ST_HMOD_GO, ST_HMOD_WAIT, ST_NMOD_GO, ST_NMOD_WAIT,
        ST_A_RD1, ST_A_RD0, ST_A_CHK,
        ST_A_SH_RD, ST_A_SH_WR, ST_A_SH_LAST,
        ST_A_CP_RD, ST_A_CP_WR, ST_ZERO_OTH,
        ST_F_RDL, ST_F_CHKL, ST_F_SP_RD, ST_F_SP_WR, ST_F_HZ, ST_F_HL,
        ST_F_SC_RD, ST_F_SC_CHK, ST_F_INS, ST_DONE
    } cfb_state_t;

    typedef enum logic {BLK_HEAD, BLK_OTHER} blk_sel_t;

    typedef enum logic [2:0] {
        WORD_IDX, WORD_IDX1, WORD_KIDX, WORD_ONE, WORD_ZERO, WORD_LAST
    } word_sel_t;

    typedef enum logic [1:0] {DATA_ZERO, DATA_RD, DATA_NUM} data_sel_t;

    typedef enum logic [1:0] {IDX_HOLD, IDX_ZERO, IDX_ONE, IDX_INC} idx_op_t;

    typedef enum logic [1:0] {DIV_PER, DIV_HEAD, DIV_HMOD, DIV_NMOD} div_sel_t;

    typedef struct packed {
        logic      in_ready;
        logic      clr_en;
        logic      div_start;
        div_sel_t  div_sel;
        logic      rd_en;
        blk_sel_t  rd_blk;
        word_sel_t rd_word;
        logic      wr_en;
        blk_sel_t  wr_blk;
        word_sel_t wr_word;
        data_sel_t wr_data;
        idx_op_t   idx_op;
        logic      cap_w1;
        logic      num_from_list;
        logic      set_empty;
        logic      cap_kidx;
        logic      out_load;
    } cfb_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic kind;
        logic clr_last;
        logic div_done;
        logic idx_last;
        logic idx_shl;
        logic w1_zero;
        logic rd_zero;
        logic alias_head;
        logic out_free;
    } cfb_sts_t;

endpackage

FILE: sv/cfb_div.sv
// ---------------------------------------------------------------------------
// cfb_div
// Restoring divider, one quotient bit per cycle; gives the quotient.
// ---------------------------------------------------------------------------
module cfb_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [cfb_pkg::DIV_W-1:0] num,
    input  logic [cfb_pkg::DIV_W-1:0] den,
    output logic                     busy,
    output logic                     done,
    output logic [cfb_pkg::DIV_W-1:0] quo
);
    import cfb_pkg::*;

    localparam int CW = $clog2(DIV_W);

    logic [DIV_W-1:0] a_reg, d_reg;
    logic [DIV_W:0]   r_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, done_reg;
    logic [DIV_W:0]   trial;
    logic             fits;

    // shift in the next dividend bit and try the subtract
    assign trial = {r_reg[DIV_W-1:0], a_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // operand and partial remainder registers
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= num;
            d_reg <= den;
            r_reg <= '0;
        end else if (busy_reg) begin
            a_reg <= {a_reg[DIV_W-2:0], fits};
            r_reg <= fits ? (trial - {1'b0, d_reg}) : trial;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = a_reg;

endmodule

FILE: sv/cfb_ctrl.sv
// ---------------------------------------------------------------------------
// cfb_ctrl
// Sequencer: clearing pass, head position, then the word passes of one op.
// ---------------------------------------------------------------------------
module cfb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfb_pkg::cfb_sts_t sts,
    output cfb_pkg::cfb_cmd_t cmd
);
    import cfb_pkg::*;

    cfb_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (sts.clr_last) state_next = ST_IDLE;
            ST_IDLE:      if (sts.in_valid) state_next = ST_PER_GO;
            ST_PER_GO:    state_next = ST_PER_WAIT;
            ST_PER_WAIT:  if (sts.div_done) state_next = ST_HEAD_GO;
            ST_HEAD_GO:   state_next = ST_HEAD_WAIT;
            ST_HEAD_WAIT: if (sts.div_done) state_next = ST_HMOD_GO;
            ST_HMOD_GO:   state_next = ST_HMOD_WAIT;
            ST_HMOD_WAIT: begin
                if (sts.div_done) begin
                    state_next = (sts.kind == KIND_FREE) ? ST_NMOD_GO : ST_A_RD1;
                end
            end
            ST_NMOD_GO:   state_next = ST_NMOD_WAIT;
            ST_NMOD_WAIT: begin
                if (sts.div_done) begin
                    priority if (sts.kind == KIND_FREE) state_next = ST_F_RDL;
                    else if (sts.w1_zero)               state_next = ST_A_CP_RD;
                    else                                state_next = ST_A_SH_RD;
                end
            end
            ST_A_RD1:     state_next = ST_A_RD0;
            ST_A_RD0:     state_next = ST_A_CHK;
            ST_A_CHK:     state_next = (sts.w1_zero && sts.rd_zero) ? ST_DONE : ST_NMOD_GO;
            ST_A_SH_RD:   state_next = ST_A_SH_WR;
            ST_A_SH_WR:   state_next = sts.idx_shl ? ST_A_SH_LAST : ST_A_SH_RD;
            ST_A_SH_LAST: state_next = ST_ZERO_OTH;
            ST_A_CP_RD:   state_next = ST_A_CP_WR;
            ST_A_CP_WR:   state_next = sts.idx_last ? ST_ZERO_OTH : ST_A_CP_RD;
            ST_ZERO_OTH: begin
                if (sts.idx_last) begin
                    state_next = (sts.kind == KIND_FREE) ? ST_F_INS : ST_DONE;
                end
            end
            ST_F_RDL:     state_next = ST_F_CHKL;
            ST_F_CHKL:    state_next = sts.rd_zero ? ST_F_SC_RD : ST_F_SP_RD;
            ST_F_SP_RD:   state_next = ST_F_SP_WR;
            ST_F_SP_WR:   state_next = sts.idx_last ? ST_F_HZ : ST_F_SP_RD;
            ST_F_HZ:      if (sts.idx_last) state_next = ST_F_HL;
            ST_F_HL:      state_next = ST_DONE;
            ST_F_SC_RD:   state_next = ST_F_SC_CHK;
            ST_F_SC_CHK: begin
                priority if (!sts.rd_zero) state_next = ST_F_SC_RD;
                else if (sts.alias_head)   state_next = ST_F_INS;
                else                       state_next = ST_ZERO_OTH;
            end
            ST_F_INS:     state_next = ST_DONE;
            ST_DONE:      if (sts.out_free) state_next = ST_IDLE;
            default:      state_next = ST_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        cmd = '0;
        cmd.div_sel = DIV_PER;
        cmd.rd_blk  = BLK_HEAD;
        cmd.rd_word = WORD_IDX;
        cmd.wr_blk  = BLK_HEAD;
        cmd.wr_word = WORD_IDX;
        cmd.wr_data = DATA_ZERO;
        cmd.idx_op  = IDX_HOLD;
        unique case (state_reg)
            ST_CLEAR:     cmd.clr_en = 1'b1;
            ST_IDLE:      cmd.in_ready = 1'b1;
            ST_PER_GO:    cmd.div_start = 1'b1;
            ST_PER_WAIT:  cmd.div_sel = DIV_PER;
            ST_HEAD_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_HEAD;
            end
            ST_HEAD_WAIT: cmd.div_sel = DIV_HEAD;
            ST_HMOD_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_HMOD;
            end
            ST_HMOD_WAIT: cmd.div_sel = DIV_HMOD;
            ST_NMOD_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_NMOD;
            end
            ST_NMOD_WAIT: begin
                cmd.div_sel = DIV_NMOD;
                cmd.idx_op  = (sts.kind == KIND_ALLOC && !sts.w1_zero) ? IDX_ONE : IDX_ZERO;
            end
            ST_A_RD1: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_word = WORD_ONE;
            end
            ST_A_RD0: begin
                cmd.cap_w1  = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_word = WORD_ZERO;
            end
            ST_A_CHK: begin
                if (sts.w1_zero && sts.rd_zero) begin
                    cmd.set_empty = 1'b1;
                end else begin
                    cmd.num_from_list = 1'b1;
                end
            end
            ST_A_SH_RD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_word = WORD_IDX1;
            end
            ST_A_SH_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_data = DATA_RD;
                cmd.idx_op  = IDX_INC;
            end
            ST_A_SH_LAST: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_word = WORD_LAST;
                cmd.idx_op  = IDX_ZERO;
            end
            ST_A_CP_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_blk = BLK_OTHER;
            end
            ST_A_CP_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_data = DATA_RD;
                cmd.idx_op  = sts.idx_last ? IDX_ZERO : IDX_INC;
            end
            ST_ZERO_OTH: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_blk = BLK_OTHER;
                cmd.idx_op = IDX_INC;
            end
            ST_F_RDL: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_word = WORD_LAST;
            end
            ST_F_CHKL:    cmd.idx_op = IDX_ZERO;
            ST_F_SP_RD:   cmd.rd_en = 1'b1;
            ST_F_SP_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_blk  = BLK_OTHER;
                cmd.wr_data = DATA_RD;
                cmd.idx_op  = sts.idx_last ? IDX_ZERO : IDX_INC;
            end
            ST_F_HZ: begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = IDX_INC;
            end
            ST_F_HL: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_word = WORD_ZERO;
                cmd.wr_data = DATA_NUM;
            end
            ST_F_SC_RD:   cmd.rd_en = 1'b1;
            ST_F_SC_CHK: begin
                if (sts.rd_zero) begin
                    cmd.cap_kidx = 1'b1;
                    cmd.idx_op   = IDX_ZERO;
                end else begin
                    cmd.idx_op = IDX_INC;
                end
            end
            ST_F_INS: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_word = WORD_KIDX;
                cmd.wr_data = DATA_NUM;
            end
            ST_DONE:      cmd.out_load = sts.out_free;
            default:      cmd = '0;
        endcase
    end

endmodule

FILE: sv/cfb_dp.sv
// ---------------------------------------------------------------------------
// cfb_dp
// Datapath: block store, head position arithmetic, word index, result beat.
// ---------------------------------------------------------------------------
module cfb_dp #(
    parameter int WORDS_PER_BLOCK = 64,
    parameter int NUM_BLOCKS      = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cfb_pkg::cfb_cmd_t               cmd,
    output cfb_pkg::cfb_sts_t               sts,
    input  logic                            s_valid,
    input  cfb_pkg::cfb_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cfb_pkg::cfb_out_t               m_data,
    input  logic                            cfg_valid,
    input  logic [cfb_pkg::CFG_IW-1:0]      cfg_index,
    input  logic [cfb_pkg::CFG_DW-1:0]      cfg_data
);
    import cfb_pkg::*;

    localparam int DEPTH = NUM_BLOCKS * WORDS_PER_BLOCK;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(NUM_BLOCKS);
    localparam int IW    = $clog2(WORDS_PER_BLOCK);
    localparam logic [AW-1:0] WPB_A = AW'(WORDS_PER_BLOCK);

    // reciprocal of NUM_BLOCKS, exact for every operand below 2**DIV_W
    localparam int          MSH    = 34;
    localparam int          MPW    = DIV_W + 31;
    localparam longint      MRECIP = ((longint'(1) << MSH) + longint'(NUM_BLOCKS) - longint'(1))
                                   / longint'(NUM_BLOCKS);
    localparam logic [30:0] MRECIP_W = 31'(MRECIP);

    logic [12:0]      bpb_reg;
    logic [15:0]      ic_reg;
    logic [10:0]      bpi_reg;
    logic [15:0]      cnt_reg, cnt_next;
    logic [AW-1:0]    clr_reg;
    logic [IW-1:0]    idx_reg, kidx_reg;
    logic [12:0]      per_reg;
    logic [DIV_W-1:0] hpos_reg;
    logic [BW-1:0]    hblk_reg, oblk_reg;
    logic [7:0]       num_reg, w1_reg, rdata_reg;
    logic             kind_reg, empty_reg, m_valid_reg;
    cfb_out_t         m_data_reg;
    logic [DIV_W-1:0] mx_reg, mq_reg;
    logic             mod_s1_reg, mod_s2_reg;

    logic [7:0]       mem [DEPTH];

    logic             accept, degen, div_busy, div_done, op_done, mod_sel;
    logic [DIV_W-1:0] div_num, div_den, div_quo, mod_rem;
    logic [MPW-1:0]   mprod;
    logic [AW-1:0]    rd_addr, op_waddr, waddr;
    logic [7:0]       wdata;
    logic             we;

    assign accept = s_valid && cmd.in_ready;
    assign degen  = (bpi_reg == '0) || (bpb_reg < {2'b00, bpi_reg});

    // word offset within a block
    function automatic logic [IW-1:0] word_of(input word_sel_t sel, input logic [IW-1:0] idx,
                                              input logic [IW-1:0] kidx);
        logic [IW-1:0] w;
        unique case (sel)
            WORD_IDX:  w = idx;
            WORD_IDX1: w = idx + 1'b1;
            WORD_KIDX: w = kidx;
            WORD_ONE:  w = IW'(1);
            WORD_ZERO: w = '0;
            WORD_LAST: w = IW'(WORDS_PER_BLOCK - 1);
            default:   w = idx;
        endcase
        return w;
    endfunction

    // configuration writes; a write to the initial count register is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpb_reg <= BPB_RST;
            ic_reg  <= IC_RST;
            bpi_reg <= BPI_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BYTES_PER_BLOCK:    bpb_reg <= cfg_data[12:0];
                CFG_INODE_COUNT:        ic_reg  <= cfg_data;
                CFG_BYTES_PER_INODE:    bpi_reg <= cfg_data[10:0];
                CFG_INITIAL_FREE_COUNT: ;
                default:                ;
            endcase
        end
    end

    // divider operands
    always_comb begin
        unique case (cmd.div_sel)
            DIV_PER: begin
                div_num = DIV_W'(bpb_reg);
                div_den = DIV_W'(bpi_reg);
            end
            DIV_HEAD: begin
                div_num = DIV_W'(ic_reg) + DIV_W'(per_reg) - DIV_W'(1);
                div_den = DIV_W'(per_reg);
            end
            DIV_HMOD: begin
                div_num = hpos_reg;
                div_den = DIV_W'(NUM_BLOCKS);
            end
            DIV_NMOD: begin
                div_num = DIV_W'(num_reg);
                div_den = DIV_W'(NUM_BLOCKS);
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    assign mod_sel = (cmd.div_sel == DIV_HMOD) || (cmd.div_sel == DIV_NMOD);

    cfb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start && !mod_sel),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_quo)
    );

    // reduce modulo NUM_BLOCKS: quotient by reciprocal, then remainder
    assign mprod   = MPW'(mx_reg) * MPW'(MRECIP_W);
    assign mod_rem = mx_reg - DIV_W'(mq_reg * DIV_W'(NUM_BLOCKS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_s1_reg <= 1'b0;
            mod_s2_reg <= 1'b0;
        end else begin
            mod_s1_reg <= cmd.div_start && mod_sel;
            mod_s2_reg <= mod_s1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start && mod_sel) begin
            mx_reg <= div_num;
        end
        if (mod_s1_reg) begin
            mq_reg <= DIV_W'(mprod[MPW-1:MSH]);
        end
    end

    assign op_done = div_done || mod_s2_reg;

    // capture divider results
    always_ff @(posedge aclk) begin
        if (op_done) begin
            unique case (cmd.div_sel)
                DIV_PER:  per_reg  <= degen ? 13'd1 : div_quo[12:0];
                DIV_HEAD: hpos_reg <= div_quo + DIV_W'(1);
                DIV_HMOD: hblk_reg <= mod_rem[BW-1:0];
                DIV_NMOD: oblk_reg <= mod_rem[BW-1:0];
                default:  ;
            endcase
        end
    end

    // item capture, list words and word index
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_data.kind;
            num_reg  <= s_data.freed_block;
        end else if (cmd.num_from_list) begin
            num_reg <= (w1_reg != '0) ? w1_reg : rdata_reg;
        end
        if (accept) begin
            empty_reg <= 1'b0;
        end else if (cmd.set_empty) begin
            empty_reg <= 1'b1;
        end
        if (cmd.cap_w1) begin
            w1_reg <= rdata_reg;
        end
        if (cmd.cap_kidx) begin
            kidx_reg <= idx_reg;
        end
        unique case (cmd.idx_op)
            IDX_HOLD: ;
            IDX_ZERO: idx_reg <= '0;
            IDX_ONE:  idx_reg <= IW'(1);
            IDX_INC:  idx_reg <= idx_reg + 1'b1;
            default:  ;
        endcase
    end

    // store addressing
    assign rd_addr  = AW'(cmd.rd_blk == BLK_HEAD ? hblk_reg : oblk_reg) * WPB_A
                    + AW'(word_of(cmd.rd_word, idx_reg, kidx_reg));
    assign op_waddr = AW'(cmd.wr_blk == BLK_HEAD ? hblk_reg : oblk_reg) * WPB_A
                    + AW'(word_of(cmd.wr_word, idx_reg, kidx_reg));
    assign we       = cmd.clr_en || cmd.wr_en;
    assign waddr    = cmd.clr_en ? clr_reg : op_waddr;

    always_comb begin
        unique case (cmd.wr_data)
            DATA_ZERO: wdata = '0;
            DATA_RD:   wdata = rdata_reg;
            DATA_NUM:  wdata = num_reg;
            default:   wdata = '0;
        endcase
        if (cmd.clr_en) begin
            wdata = '0;
        end
    end

    // block store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // clearing pass address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_en) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // free counter update for the finished op
    always_comb begin
        cnt_next = cnt_reg;
        priority if (empty_reg) begin
            cnt_next = cnt_reg;
        end else if (kind_reg == KIND_FREE) begin
            if (cnt_reg != 16'hFFFF) cnt_next = cnt_reg + 1'b1;
        end else begin
            if (cnt_reg != '0) cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= FREE_RST;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                cnt_reg     <= cnt_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result beat
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.granted_block <= (empty_reg || kind_reg == KIND_FREE) ? 8'd0 : num_reg;
            m_data_reg.status        <= empty_reg ? STATUS_EMPTY : STATUS_OK;
            m_data_reg.free_count    <= cnt_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.in_valid   = s_valid;
    assign sts.kind       = kind_reg;
    assign sts.clr_last   = clr_reg == AW'(DEPTH - 1);
    assign sts.div_done   = op_done;
    assign sts.idx_last   = idx_reg == IW'(WORDS_PER_BLOCK - 1);
    assign sts.idx_shl    = idx_reg == IW'(WORDS_PER_BLOCK - 2);
    assign sts.w1_zero    = w1_reg == '0;
    assign sts.rd_zero    = rdata_reg == '0;
    assign sts.alias_head = oblk_reg == hblk_reg;
    assign sts.out_free   = !m_valid_reg || m_ready;

    // checks
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a beat still waiting");
    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> !cmd.clr_en)
        else $error("op write during clearing pass");
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_grant_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && !empty_reg && kind_reg == KIND_ALLOC) |=> (m_data.granted_block != 8'd0))
        else $error("successful allocate granted block zero");

endmodule

FILE: sv/chained_free_block_list_allocator.sv
// ---------------------------------------------------------------------------
// chained_free_block_list_allocator
// Hands out and takes back block numbers through a free list held in a store.
// ---------------------------------------------------------------------------
// channel  ports               direction  beat
// s_       s_valid/s_ready     in         cfb_in_t  {kind, freed_block}
// m_       m_valid/m_ready     out        cfb_out_t {granted_block, status, free_count}
// cfg_     cfg_valid/cfg_ready in         cfg_index, cfg_data
//
// After reset a clearing pass writes NUM_BLOCKS*WORDS_PER_BLOCK zero words, one a
// cycle, before the first item is taken; configuration is taken throughout.
// Each item first finds the head block with two bit-serial divides and reduces
// block numbers modulo NUM_BLOCKS, then runs word passes in which words are copied,
// shifted, scanned or cleared. One item is in work at a time; a finished result
// waits in the output register and the next item is accepted meanwhile.
module chained_free_block_list_allocator #(
    parameter int WORDS_PER_BLOCK = 64,
    parameter int NUM_BLOCKS      = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  cfb_pkg::cfb_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output cfb_pkg::cfb_out_t           m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cfb_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [cfb_pkg::CFG_DW-1:0]  cfg_data
);
    import cfb_pkg::*;

    cfb_cmd_t cmd;
    cfb_sts_t sts;

    cfb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    cfb_dp #(
        .WORDS_PER_BLOCK (WORDS_PER_BLOCK),
        .NUM_BLOCKS      (NUM_BLOCKS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    assign s_ready   = cmd.in_ready;
    assign cfg_ready = 1'b1;

endmodule

FILE: verif/chained_free_block_list_allocator_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chained_free_block_list_allocator_test
// Drives allocate and free beats through the allocator under several layouts,
// predicts each answer from a private copy of the block store and the counter,
// and checks every result beat field by field in order of arrival.
// ---------------------------------------------------------------------------
module chained_free_block_list_allocator_test;
    import cfb_pkg::*;

    localparam int WPB       = 64;
    localparam int NBLK      = 256;
    localparam int WD_LIMIT  = 200000;
    localparam int HOLD_LEN  = 3000;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    cfb_in_t             s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    cfb_out_t            m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_IW-1:0]   cfg_index = '0;
    logic [CFG_DW-1:0]   cfg_data  = '0;

    chained_free_block_list_allocator #(.WORDS_PER_BLOCK(WPB), .NUM_BLOCKS(NBLK)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // shadow state of the allocator
    logic [7:0]  shadow_store [NBLK*WPB];
    logic [15:0] shadow_count;
    logic [12:0] lay_bpb;
    logic [15:0] lay_inodes;
    logic [10:0] lay_bpi;
    logic [15:0] lay_init_free;

    cfb_in_t  op_q [$];
    cfb_out_t answer_q [$];
    int       errors   = 0;
    int       n_answers = 0;
    bit       quiet    = 1'b0;
    bit       hold_done = 1'b0;

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic int head_block();
        int per;
        per = 1;
        if (lay_bpi != 0 && lay_bpb >= lay_bpi)
            per = int'(lay_bpb) / int'(lay_bpi);
        return ((int'(lay_inodes) + per - 1) / per + 1) % NBLK;
    endfunction

    function automatic cfb_out_t allocate_or_free(cfb_in_t op);
        logic [7:0] snap [WPB];
        logic [7:0] grant;
        cfb_out_t   r;
        int         h;
        int         b;
        bit         placed;
        h = head_block() * WPB;
        r = '0;
        for (int i = 0; i < WPB; i++) snap[i] = shadow_store[h+i];
        if (op.kind == KIND_ALLOC) begin
            if (snap[1] != 0) begin
                grant = snap[1];
                for (int i = 1; i < WPB-1; i++) shadow_store[h+i] = snap[i+1];
                shadow_store[h+WPB-1] = 8'd0;
            end else if (snap[0] == 0) begin
                r.status     = STATUS_EMPTY;
                r.free_count = shadow_count;
                return r;
            end else begin
                // pull the linked block into the head and grant the link itself
                grant = snap[0];
                b = (int'(grant) % NBLK) * WPB;
                for (int i = 0; i < WPB; i++) snap[i] = shadow_store[b+i];
                for (int i = 0; i < WPB; i++) shadow_store[h+i] = snap[i];
            end
            b = (int'(grant) % NBLK) * WPB;
            for (int i = 0; i < WPB; i++) shadow_store[b+i] = 8'd0;
            if (shadow_count != 0) shadow_count--;
            r.granted_block = grant;
            r.status        = STATUS_OK;
        end else begin
            b = (int'(op.freed_block) % NBLK) * WPB;
            if (snap[WPB-1] != 0) begin
                // head full: spill it into the freed block and relink
                for (int i = 0; i < WPB; i++) shadow_store[b+i] = snap[i];
                for (int i = 0; i < WPB; i++) snap[i] = 8'd0;
                snap[0] = op.freed_block;
            end else begin
                for (int i = 0; i < WPB; i++) shadow_store[b+i] = 8'd0;
                placed = 1'b0;
                for (int i = 0; i < WPB; i++) begin
                    if (!placed && snap[i] == 0) begin
                        snap[i] = op.freed_block;
                        placed  = 1'b1;
                    end
                end
            end
            for (int i = 0; i < WPB; i++) shadow_store[h+i] = snap[i];
            if (shadow_count != 16'hFFFF) shadow_count++;
            r.status = STATUS_OK;
        end
        r.free_count = shadow_count;
        return r;
    endfunction

    // driver: present queued operations, predict on each accepted beat
    int src_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                answer_q.push_back(allocate_or_free(s_data));
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 11) == 0) begin
                    src_gap = $urandom_range(0, 16);
                    s_valid <= 1'b0;
                end else if (op_q.size() != 0) begin
                    s_data  <= op_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: pace m_ready, hold off once for a long stretch, check beats
    int sink_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_answers++;
                if (answer_q.size() == 0) begin
                    report($sformatf("unexpected beat %p", m_data));
                end else begin
                    cfb_out_t want;
                    want = answer_q.pop_front();
                    if (m_data.granted_block !== want.granted_block)
                        report($sformatf("granted_block %0d want %0d",
                                         m_data.granted_block, want.granted_block));
                    if (m_data.status !== want.status)
                        report($sformatf("status %0d want %0d", m_data.status, want.status));
                    if (m_data.free_count !== want.free_count)
                        report($sformatf("free_count %0d want %0d",
                                         m_data.free_count, want.free_count));
                end
            end
            if (!hold_done && n_answers == 40) begin
                hold_done = 1'b1;
                sink_gap  = HOLD_LEN;
                m_ready  <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: count stalled cycles while work is outstanding
    int stall_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) ||
            (op_q.size() == 0 && !s_valid && answer_q.size() == 0))
            stall_cycles = 0;
        else if (++stall_cycles >= WD_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one register write beat; the channel then idles before the task returns
    task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BYTES_PER_BLOCK:    lay_bpb       = val[12:0];
            CFG_INODE_COUNT:        lay_inodes    = val;
            CFG_BYTES_PER_INODE:    lay_bpi       = val[10:0];
            CFG_INITIAL_FREE_COUNT: lay_init_free = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_layout(int bpb, int inodes, int bpi, int init_free);
        cfg_write(CFG_BYTES_PER_BLOCK, bpb[15:0]);
        cfg_write(CFG_INODE_COUNT, inodes[15:0]);
        cfg_write(CFG_BYTES_PER_INODE, bpi[15:0]);
        cfg_write(CFG_INITIAL_FREE_COUNT, init_free[15:0]);
    endtask

    task automatic push_op(logic kind, logic [7:0] num);
        cfb_in_t op;
        op.kind        = kind;
        op.freed_block = num;
        op_q.push_back(op);
    endtask

    // a fill-heavy stretch builds chained lists, a drain-heavy one walks them
    task automatic push_mix(int count, int free_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(1, 100) <= free_pct)
                push_op(KIND_FREE, ($urandom_range(0, 40) == 0) ? 8'd0
                                                                 : 8'($urandom_range(1, 255)));
            else
                push_op(KIND_ALLOC, 8'($urandom));
        end
    endtask

    task automatic drain();
        while (op_q.size() != 0 || s_valid || answer_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < NBLK*WPB; i++) shadow_store[i] = 8'd0;
        lay_bpb       = BPB_RST;
        lay_inodes    = IC_RST;
        lay_bpi       = BPI_RST;
        lay_init_free = FREE_RST;
        shadow_count  = FREE_RST;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty list, zero number, link slot, head aliasing, limits
        push_op(KIND_ALLOC, 8'd0);
        push_op(KIND_FREE, 8'd0);
        push_op(KIND_ALLOC, 8'hFF);
        push_op(KIND_FREE, 8'd255);
        push_op(KIND_ALLOC, 8'd0);
        push_op(KIND_FREE, 8'd17);
        push_op(KIND_ALLOC, 8'd0);
        push_op(KIND_ALLOC, 8'd0);
        for (int i = 1; i <= 4; i++) push_op(KIND_FREE, 8'(i * 37));
        push_op(KIND_FREE, 8'd17);
        for (int i = 0; i < 6; i++) push_op(KIND_ALLOC, 8'd0);
        drain();

        // random phases over several layouts, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_layout(512, 64, 128, 65535);
                1: set_layout(4096, 0, 32, 0);
                2: set_layout(64, 65535, 1024, 65535);
                3: set_layout(64, 65535, 0, 0);
                4: set_layout($urandom, $urandom, $urandom, $urandom);
                default: set_layout($urandom_range(64, 4096), $urandom_range(0, 65535),
                                    $urandom_range(32, 1024), $urandom_range(0, 65535));
            endcase
            quiet = (ph == 5) || ($urandom_range(0, 3) == 0);
            push_mix(140, 85);
            push_mix(90, 15);
            drain();
        end

        repeat (1000) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
